// ===== rtl/core/vpn_client_session_table_defines.svh =====
// Assertion macros shared by the checker of the client session table.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef VPN_CLIENT_SESSION_TABLE_DEFINES_SVH
`define VPN_CLIENT_SESSION_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VCST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define VCST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/vcst_pkg.sv =====
// Package of the client session table: codes, entry layout and sequencer states.
// Used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package vcst_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_BY_TUN = 2'd1;
  localparam logic [1:0] KIND_BY_UDP = 2'd2;
  localparam logic [1:0] KIND_VERIFY = 2'd3;

  localparam logic [2:0] STAT_OK           = 3'd0;
  localparam logic [2:0] STAT_IN_USE       = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND    = 3'd2;
  localparam logic [2:0] STAT_OUT_OF_POOL  = 3'd3;
  localparam logic [2:0] STAT_UDP_MISMATCH = 3'd4;

  // One table entry as stored in the RAM; the in-use flag travels with the data.
  typedef struct packed {
    logic        used;
    logic [31:0] udp_ip;
    logic [15:0] udp_port;
    logic [7:0]  key;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_READ,
    S_CHECK,
    S_SCAN,
    S_ADD,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/vpn_client_session_table.sv =====
// Client session table: one slot per pool tunnel IP, each holding a UDP address,
// port and key byte in a single RAM (vcst_ram), with an in-use flag per entry.
// After reset a clearing pass writes every slot as free, one per cycle, so the
// block takes no item until that pass is done. An item is then taken only while
// the sequencer is idle. Add, lookup by tunnel IP and verified lookup go from
// transfer to result through one 32-bit add of the shared adder for the slot
// index, one RAM read and one compare. A tunnel IP outside the pool skips the
// read and the compare. Lookup by UDP address walks the RAM one slot per cycle
// through the shared comparator and stops at the first match. A finished result
// sits in the output register; the next item may be taken meanwhile, but its
// result waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module vpn_client_session_table
  import vcst_pkg::*;
#(
  parameter int POOL_SIZE = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_tun_ip,
  input  wire logic [31:0] in_udp_ip,
  input  wire logic [15:0] in_udp_port,
  input  wire logic [7:0]  in_key_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_found_tun_ip,
  output logic [31:0]      out_found_udp_ip,
  output logic [15:0]      out_found_udp_port,
  output logic [7:0]       out_found_key
);

  localparam int SLOT_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W   = $clog2(POOL_SIZE + 1);
  localparam int ENTRY_W = $bits(entry_t);

  state_t state_r, state_nxt;

  logic [31:0]       base_r;
  logic [1:0]        kind_r, kind_nxt;
  logic [31:0]       tun_r, tun_nxt;
  logic [31:0]       uip_r, uip_nxt;
  logic [15:0]       port_r, port_nxt;
  logic [7:0]        key_r, key_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;

  logic [2:0]  res_status_r, res_status_nxt;
  logic [31:0] res_tun_r, res_tun_nxt;
  logic [31:0] res_uip_r, res_uip_nxt;
  logic [15:0] res_port_r, res_port_nxt;
  logic [7:0]  res_key_r, res_key_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [31:0] out_tun_r, out_tun_nxt;
  logic [31:0] out_uip_r, out_uip_nxt;
  logic [15:0] out_port_r, out_port_nxt;
  logic [7:0]  out_key_r, out_key_nxt;

  logic              in_xfer;
  logic              out_load;
  logic              scan_done;
  logic              in_pool;
  logic              udp_match;
  logic              hit;
  logic [31:0]       alu_a, alu_b, alu_sum;
  logic              alu_cin;
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_q;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign scan_done = (cnt_r == CNT_W'(POOL_SIZE));

  // Shared adder: slot = tun - base during S_CALC, tunnel IP = base + slot otherwise.
  always_comb begin
    if (state_r == S_CALC) begin
      alu_a   = tun_r;
      alu_b   = ~base_r;
      alu_cin = 1'b1;
    end else begin
      alu_a   = base_r;
      alu_b   = 32'(slot_r);
      alu_cin = 1'b0;
    end
  end
  assign alu_sum = alu_a + alu_b + 32'(alu_cin);
  assign in_pool = (alu_sum < 32'(POOL_SIZE));

  // Shared comparator on the entry word just read.
  assign rd_q      = entry_t'(ram_rdata);
  assign udp_match = (rd_q.udp_ip == uip_r) && (rd_q.udp_port == port_r);
  assign hit       = rd_vld_r && rd_q.used && udp_match;

  vcst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cnt_r == CNT_W'(POOL_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_kind == KIND_BY_UDP) ? S_SCAN : S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = in_pool ? S_READ : S_RESP;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_ADD;
        end else if (scan_done && rd_vld_r) begin
          state_nxt = S_RESP;
        end
      end
      S_ADD: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    kind_nxt       = kind_r;
    tun_nxt        = tun_r;
    uip_nxt        = uip_r;
    port_nxt       = port_r;
    key_nxt        = key_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_slot_nxt    = rd_slot_r;
    res_status_nxt = res_status_r;
    res_tun_nxt    = res_tun_r;
    res_uip_nxt    = res_uip_r;
    res_port_nxt   = res_port_r;
    res_key_nxt    = res_key_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = slot_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[SLOT_W-1:0];
        cnt_nxt   = cnt_r + 1'b1;
      end
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_kind;
          tun_nxt  = in_tun_ip;
          uip_nxt  = in_udp_ip;
          port_nxt = in_udp_port;
          key_nxt  = in_key_byte;
          cnt_nxt  = '0;
        end
      end
      S_CALC: begin
        slot_nxt = alu_sum[SLOT_W-1:0];
        if (!in_pool) begin
          res_status_nxt = STAT_OUT_OF_POOL;
          res_tun_nxt    = '0;
          res_uip_nxt    = '0;
          res_port_nxt   = '0;
          res_key_nxt    = '0;
        end
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_CHECK: begin
        // Defaults describe a successful lookup of the addressed slot.
        res_status_nxt = STAT_OK;
        res_tun_nxt    = tun_r;
        res_uip_nxt    = rd_q.udp_ip;
        res_port_nxt   = rd_q.udp_port;
        res_key_nxt    = rd_q.key;
        if (kind_r == KIND_ADD) begin
          if (rd_q.used) begin
            res_status_nxt = STAT_IN_USE;
          end else begin
            ram_we             = 1'b1;
            ram_wdata.used     = 1'b1;
            ram_wdata.udp_ip   = uip_r;
            ram_wdata.udp_port = port_r;
            ram_wdata.key      = key_r;
            res_uip_nxt        = uip_r;
            res_port_nxt       = port_r;
            res_key_nxt        = key_r;
          end
        end else if (!rd_q.used) begin
          res_status_nxt = STAT_NOT_FOUND;
        end else if (kind_r == KIND_VERIFY && !udp_match) begin
          res_status_nxt = STAT_UDP_MISMATCH;
        end
        if (res_status_nxt != STAT_OK) begin
          res_tun_nxt  = '0;
          res_uip_nxt  = '0;
          res_port_nxt = '0;
          res_key_nxt  = '0;
        end
      end
      S_SCAN: begin
        // One read issued per cycle; the compare works on the read of the cycle before.
        if (hit) begin
          slot_nxt       = rd_slot_r;
          res_status_nxt = STAT_OK;
          res_uip_nxt    = rd_q.udp_ip;
          res_port_nxt   = rd_q.udp_port;
          res_key_nxt    = rd_q.key;
        end else if (!scan_done) begin
          ram_re      = 1'b1;
          ram_raddr   = cnt_r[SLOT_W-1:0];
          rd_vld_nxt  = 1'b1;
          rd_slot_nxt = cnt_r[SLOT_W-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end else if (rd_vld_r) begin
          res_status_nxt = STAT_NOT_FOUND;
          res_tun_nxt    = '0;
          res_uip_nxt    = '0;
          res_port_nxt   = '0;
          res_key_nxt    = '0;
        end
      end
      S_ADD: begin
        res_tun_nxt = alu_sum;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_tun_nxt    = out_tun_r;
    out_uip_nxt    = out_uip_r;
    out_port_nxt   = out_port_r;
    out_key_nxt    = out_key_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_tun_nxt    = res_tun_r;
      out_uip_nxt    = res_uip_r;
      out_port_nxt   = res_port_r;
      out_key_nxt    = res_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      base_r      <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tun_r        <= tun_nxt;
    uip_r        <= uip_nxt;
    port_r       <= port_nxt;
    key_r        <= key_nxt;
    slot_r       <= slot_nxt;
    rd_slot_r    <= rd_slot_nxt;
    res_status_r <= res_status_nxt;
    res_tun_r    <= res_tun_nxt;
    res_uip_r    <= res_uip_nxt;
    res_port_r   <= res_port_nxt;
    res_key_r    <= res_key_nxt;
    out_status_r <= out_status_nxt;
    out_tun_r    <= out_tun_nxt;
    out_uip_r    <= out_uip_nxt;
    out_port_r   <= out_port_nxt;
    out_key_r    <= out_key_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_tun_ip   = out_tun_r;
  assign out_found_udp_ip   = out_uip_r;
  assign out_found_udp_port = out_port_r;
  assign out_found_key      = out_key_r;

endmodule
`default_nettype wire

// ===== rtl/core/vcst_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/vcst_checker.sv =====
// Port-level checker of the client session table, bound to the top level.
// Depends on vcst_pkg and vpn_client_session_table_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "vpn_client_session_table_defines.svh"
module vcst_checker
  import vcst_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_we,
  input wire logic [31:0] cfg_wdata,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_kind,
  input wire logic [31:0] in_tun_ip,
  input wire logic [31:0] in_udp_ip,
  input wire logic [15:0] in_udp_port,
  input wire logic [7:0]  in_key_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_found_tun_ip,
  input wire logic [31:0] out_found_udp_ip,
  input wire logic [15:0] out_found_udp_port,
  input wire logic [7:0]  out_found_key
);

  // A held result keeps its status and entry.
  `VCST_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_found_tun_ip) &&
    $stable(out_found_udp_ip) && $stable(out_found_udp_port) && $stable(out_found_key),
    "result changed while stalled")

  // A failed operation returns an all-zero entry.
  `VCST_ASSERT_SAME(a_fail_zero, out_valid && (out_status != STAT_OK),
    (out_found_tun_ip == '0) && (out_found_udp_ip == '0) &&
    (out_found_udp_port == '0) && (out_found_key == '0),
    "non-ok result carries entry data")

  // The sequencer works on one item at a time.
  `VCST_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall,
    "input taken again right after a transfer")

endmodule

bind vpn_client_session_table vcst_checker u_vcst_checker (.*);
`default_nettype wire
